[src/sltsw_pkg.sv]
// ----------------------------------------------------------------------------
// sltsw_pkg
// Shared types and constants for the scheduled LED time switch block.
// ----------------------------------------------------------------------------
package sltsw_pkg;

    // fixed field widths
    localparam int LED_W      = 4;
    localparam int MASK_W     = 8;
    localparam int REP_W      = 16;
    localparam int OUT_W      = 3;
    localparam int ACT_W      = 2;
    localparam int IDX_IN_W   = 3;
    localparam int FIELD_T_W  = 32;

    // stream widths
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 16;

    // item kinds carried in tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // led actions
    localparam logic [ACT_W-1:0] ACT_ON     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFF    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TOGGLE = 2'd2;

    // first valid led target number
    localparam logic [OUT_W-1:0] LED_FIRST = 3'd1;
    localparam logic [OUT_W-1:0] LED_LAST  = 3'd4;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // status from the evaluation unit
    typedef struct packed {
        logic             fire;
        logic [LED_W-1:0] led_next;
        logic [REP_W-1:0] repeats_next;
    } unit_status_t;

endpackage

[src/sltsw_ram.sv]
// ----------------------------------------------------------------------------
// sltsw_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sltsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[src/sltsw_unit.sv]
// ----------------------------------------------------------------------------
// sltsw_unit
// Shared evaluation unit: time compare, led action, time advance and
// repeat count update for the entry currently visited.
// ----------------------------------------------------------------------------
module sltsw_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                         enabled,
    input  logic [TIME_BITS-1:0]         slot_time,
    input  logic [TIME_BITS-1:0]         slot_interval,
    input  logic [sltsw_pkg::OUT_W-1:0]  slot_output,
    input  logic [sltsw_pkg::ACT_W-1:0]  slot_action,
    input  logic [sltsw_pkg::REP_W-1:0]  slot_repeats,
    input  logic [TIME_BITS-1:0]         now,
    input  logic [sltsw_pkg::LED_W-1:0]  led_cur,
    output logic [TIME_BITS-1:0]         time_next,
    output sltsw_pkg::unit_status_t      status
);

    logic                        fire;
    logic                        target_ok;
    logic [sltsw_pkg::LED_W-1:0] led_bit;
    logic [sltsw_pkg::LED_W-1:0] led_acted;
    logic                        rep_zero;

    // fire decision
    assign fire      = enabled && (slot_time == now);
    assign target_ok = (slot_output >= sltsw_pkg::LED_FIRST) &&
                       (slot_output <= sltsw_pkg::LED_LAST);
    assign led_bit   = sltsw_pkg::LED_W'(1) << (slot_output - sltsw_pkg::LED_FIRST);

    // led action
    always_comb
    begin
        led_acted = led_cur;
        if (target_ok)
        begin
            case (slot_action)
                sltsw_pkg::ACT_ON:     led_acted = led_cur | led_bit;
                sltsw_pkg::ACT_OFF:    led_acted = led_cur & ~led_bit;
                sltsw_pkg::ACT_TOGGLE: led_acted = led_cur ^ led_bit;
                default:               led_acted = led_cur;
            endcase
        end
    end

    // time advance and repeat count
    assign rep_zero  = (slot_repeats == '0);
    assign time_next = rep_zero ? slot_time : (slot_time + slot_interval);

    always_comb
    begin
        status.fire         = fire;
        status.led_next     = fire ? led_acted : led_cur;
        status.repeats_next = slot_repeats;
        if (!rep_zero && !slot_repeats[sltsw_pkg::REP_W-1])
        begin
            status.repeats_next = slot_repeats - sltsw_pkg::REP_W'(1);
        end
    end

endmodule

[src/scheduled_led_time_switches.sv]
// ----------------------------------------------------------------------------
// scheduled_led_time_switches
// Table of timed LED switch entries walked by a small sequencer.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis; tuser selects a tick (0) or an entry write (1).
// A write beat loads one table entry and returns the unchanged LED state with
// an empty fired mask.
// A tick beat walks the table one entry per cycle through one shared
// compare/add unit and the table RAM read port; s_axis_tready is low while
// the walk runs.
// Each beat gives exactly one result beat on m_axis: LED state and fired mask.
// The result sits in an output register; a new input beat is taken while it
// waits, but the next result holds back until m_axis_tready frees the
// register, stalling the sequencer.
// Reset clears all entry valid bits (all entries disabled), the LED register
// and the output valid flag; no clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
module scheduled_led_time_switches #(
    parameter int ENTRIES   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], entry_index[34:32], entry_enabled[35], entry_time[67:36],
    // entry_output[70:68], entry_action[72:71], entry_repeats[88:73],
    // entry_interval[120:89], zero fill above
    input  logic [sltsw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // led_state[3:0], fired_mask[11:4], zero fill above
    output logic [sltsw_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EN_LSB  = 0;
    localparam int TM_LSB  = 1;
    localparam int OUT_LSB = TM_LSB + TIME_BITS;
    localparam int ACT_LSB = OUT_LSB + sltsw_pkg::OUT_W;
    localparam int REP_LSB = ACT_LSB + sltsw_pkg::ACT_W;
    localparam int INT_LSB = REP_LSB + sltsw_pkg::REP_W;
    localparam int ENTRY_W = INT_LSB + TIME_BITS;

    // input fields
    logic [sltsw_pkg::FIELD_T_W-1:0] in_now;
    logic [sltsw_pkg::IDX_IN_W-1:0]  in_index;
    logic                            in_enabled;
    logic [sltsw_pkg::FIELD_T_W-1:0] in_time;
    logic [sltsw_pkg::OUT_W-1:0]     in_output;
    logic [sltsw_pkg::ACT_W-1:0]     in_action;
    logic [sltsw_pkg::REP_W-1:0]     in_repeats;
    logic [sltsw_pkg::FIELD_T_W-1:0] in_interval;

    assign in_now      = s_axis_tdata[31:0];
    assign in_index    = s_axis_tdata[34:32];
    assign in_enabled  = s_axis_tdata[35];
    assign in_time     = s_axis_tdata[67:36];
    assign in_output   = s_axis_tdata[70:68];
    assign in_action   = s_axis_tdata[72:71];
    assign in_repeats  = s_axis_tdata[88:73];
    assign in_interval = s_axis_tdata[120:89];

    // registers
    sltsw_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [sltsw_pkg::LED_W-1:0]    led_reg, led_next;
    logic [sltsw_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic [ENTRIES-1:0]             valid_reg, valid_next;
    logic                           rd_valid_reg;
    logic [TIME_BITS-1:0]           now_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [sltsw_pkg::M_TDATA_W-1:0] out_data_reg;

    // ram and unit signals
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [ENTRY_W-1:0]      write_word;
    logic [ENTRY_W-1:0]      update_word;
    logic [TIME_BITS-1:0]    time_next;
    sltsw_pkg::unit_status_t unit_status;

    logic in_beat;
    logic is_write;
    logic index_ok;
    logic scan_last;
    logic out_free;
    logic out_load;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign is_write  = (s_axis_tuser == sltsw_pkg::FUNC_WRITE);
    assign index_ok  = (32'(in_index) < ENTRIES);
    assign scan_last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    // entry word from a write beat
    always_comb
    begin
        write_word = '0;
        write_word[EN_LSB]                        = in_enabled;
        write_word[TM_LSB +: TIME_BITS]           = TIME_BITS'(in_time);
        write_word[OUT_LSB +: sltsw_pkg::OUT_W]   = in_output;
        write_word[ACT_LSB +: sltsw_pkg::ACT_W]   = in_action;
        write_word[REP_LSB +: sltsw_pkg::REP_W]   = in_repeats;
        write_word[INT_LSB +: TIME_BITS]          = TIME_BITS'(in_interval);
    end

    // updated entry after firing
    always_comb
    begin
        update_word = ram_rdata;
        update_word[TM_LSB +: TIME_BITS]         = time_next;
        update_word[REP_LSB +: sltsw_pkg::REP_W] = unit_status.repeats_next;
    end

    // shared evaluation unit
    sltsw_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_unit (
        .enabled       (rd_valid_reg && ram_rdata[EN_LSB]),
        .slot_time     (ram_rdata[TM_LSB +: TIME_BITS]),
        .slot_interval (ram_rdata[INT_LSB +: TIME_BITS]),
        .slot_output   (ram_rdata[OUT_LSB +: sltsw_pkg::OUT_W]),
        .slot_action   (ram_rdata[ACT_LSB +: sltsw_pkg::ACT_W]),
        .slot_repeats  (ram_rdata[REP_LSB +: sltsw_pkg::REP_W]),
        .now           (now_reg),
        .led_cur       (led_reg),
        .time_next     (time_next),
        .status        (unit_status)
    );

    // entry table
    sltsw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sltsw_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = is_write ? sltsw_pkg::ST_FINISH : sltsw_pkg::ST_SCAN;
                end
            end
            sltsw_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = sltsw_pkg::ST_FINISH;
                end
            end
            sltsw_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sltsw_pkg::ST_IDLE;
                end
            end
            default: state_next = sltsw_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath control
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = update_word;
        ram_raddr     = '0;
        idx_next      = idx_reg;
        led_next      = led_reg;
        mask_next     = mask_reg;
        valid_next    = valid_reg;
        out_load      = 1'b0;
        case (state_reg)
            sltsw_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_waddr     = IDX_W'(in_index);
                ram_wdata     = write_word;
                if (in_beat)
                begin
                    idx_next  = '0;
                    mask_next = '0;
                    if (is_write && index_ok)
                    begin
                        ram_we                = 1'b1;
                        valid_next[ram_waddr] = 1'b1;
                    end
                end
            end
            sltsw_pkg::ST_SCAN:
            begin
                ram_we   = unit_status.fire;
                led_next = unit_status.led_next;
                mask_next = mask_reg |
                            (sltsw_pkg::MASK_W'(unit_status.fire) << idx_reg);
                if (!scan_last)
                begin
                    ram_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            sltsw_pkg::ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sltsw_pkg::ST_IDLE;
            idx_reg       <= '0;
            led_reg       <= '0;
            mask_reg      <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            led_reg       <= led_next;
            mask_reg      <= mask_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            now_reg <= TIME_BITS'(in_now);
        end
        if (out_load)
        begin
            out_data_reg <= sltsw_pkg::M_TDATA_W'({mask_reg, led_reg});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[tb/scheduled_led_time_switches_test.sv]
// ----------------------------------------------------------------------------
// scheduled_led_time_switches_test
// Self-checking bench for the scheduled LED time switch block.
// ----------------------------------------------------------------------------
// Entry writes and time ticks go in on the input stream; a tracker class keeps
// its own copy of the switch table and LED register, predicts LED state and
// fired mask for every accepted beat, and checks each result beat in order.
// A directed opening covers wrap, forever and one-shot repeats, missing LEDs,
// the unused action and disabled entries. Random traffic follows, mostly ticks
// aimed at the predicted fire times, with gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module scheduled_led_time_switches_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                          TABLE_DEPTH = 8;
    localparam int                          RANDOM_BEATS = 1850;
    localparam logic [sltsw_pkg::ACT_W-1:0] ACT_NONE = 2'd3;
    localparam logic [sltsw_pkg::OUT_W-1:0] LED_NONE = 3'd0;

    // one input beat, unpacked
    typedef struct {
        logic                               func;
        logic [31:0]                        now_ms;
        logic [sltsw_pkg::IDX_IN_W-1:0]     index;
        logic                               enabled;
        logic [31:0]                        fire_at;
        logic [sltsw_pkg::OUT_W-1:0]        target;
        logic [sltsw_pkg::ACT_W-1:0]        action;
        logic signed [sltsw_pkg::REP_W-1:0] repeats;
        logic [31:0]                        interval;
    } switch_beat_t;

    typedef struct packed {
        logic [sltsw_pkg::MASK_W-1:0] fired_mask;
        logic [sltsw_pkg::LED_W-1:0]  led_state;
    } switch_result_t;

    // ------------------------------------------------------------------------
    // switch table tracker: predicts results and checks them in order
    // ------------------------------------------------------------------------
    class switch_tracker;
        logic                               slot_on   [TABLE_DEPTH];
        logic [31:0]                        slot_at   [TABLE_DEPTH];
        logic [sltsw_pkg::OUT_W-1:0]        slot_led  [TABLE_DEPTH];
        logic [sltsw_pkg::ACT_W-1:0]        slot_act  [TABLE_DEPTH];
        logic signed [sltsw_pkg::REP_W-1:0] slot_reps [TABLE_DEPTH];
        logic [31:0]                        slot_gap  [TABLE_DEPTH];
        logic [sltsw_pkg::LED_W-1:0]        led_reg;
        switch_result_t                     due_results[$];
        int                                 fail_count;
        int                                 checked;
        int                                 writes;
        int                                 ticks;
        int                                 firing_ticks;
        int                                 multi_fires;

        function new();
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                slot_on[k]   = 1'b0;
                slot_at[k]   = '0;
                slot_led[k]  = '0;
                slot_act[k]  = '0;
                slot_reps[k] = '0;
                slot_gap[k]  = '0;
            end
            led_reg = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // apply one accepted beat to the shadow table and queue its result
        function void take_item(switch_beat_t it);
            switch_result_t              res;
            logic [sltsw_pkg::LED_W-1:0] led_bit;
            res.fired_mask = '0;
            if (it.func == sltsw_pkg::FUNC_WRITE)
            begin
                slot_on[it.index]   = it.enabled;
                slot_at[it.index]   = it.fire_at;
                slot_led[it.index]  = it.target;
                slot_act[it.index]  = it.action;
                slot_reps[it.index] = it.repeats;
                slot_gap[it.index]  = it.interval;
                writes++;
            end
            else
            begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                begin
                    if (slot_on[k] && slot_at[k] == it.now_ms)
                    begin
                        // only leds one to four exist
                        if (slot_led[k] >= sltsw_pkg::LED_FIRST &&
                            slot_led[k] <= sltsw_pkg::LED_LAST)
                        begin
                            led_bit = sltsw_pkg::LED_W'(1) <<
                                      (slot_led[k] - sltsw_pkg::LED_FIRST);
                            case (slot_act[k])
                                sltsw_pkg::ACT_ON:     led_reg = led_reg | led_bit;
                                sltsw_pkg::ACT_OFF:    led_reg = led_reg & ~led_bit;
                                sltsw_pkg::ACT_TOGGLE: led_reg = led_reg ^ led_bit;
                                default:               ;
                            endcase
                        end
                        // zero count stays put, negative repeats forever
                        if (slot_reps[k] != 0)
                        begin
                            slot_at[k] = slot_at[k] + slot_gap[k];
                            if (slot_reps[k] > 0)
                                slot_reps[k]--;
                        end
                        res.fired_mask[k] = 1'b1;
                    end
                end
                ticks++;
                if (res.fired_mask != 0)
                    firing_ticks++;
                if ($countones(res.fired_mask) > 1)
                    multi_fires++;
            end
            res.led_state = led_reg;
            due_results.push_back(res);
        endfunction

        // compare one result beat with the oldest prediction
        function void compare_result(logic [sltsw_pkg::M_TDATA_W-1:0] data);
            switch_result_t want;
            switch_result_t got;
            got = data[sltsw_pkg::MASK_W+sltsw_pkg::LED_W-1:0];
            if (due_results.size() == 0)
            begin
                $error("unexpected result beat: led_state %0h fired_mask %0h",
                       got.led_state, got.fired_mask);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (got.led_state !== want.led_state)
            begin
                $error("led_state: expected %0h, got %0h", want.led_state, got.led_state);
                fail_count++;
            end
            if (got.fired_mask !== want.fired_mask)
            begin
                $error("fired_mask: expected %0h, got %0h", want.fired_mask, got.fired_mask);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sltsw_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                            s_axis_tuser = sltsw_pkg::FUNC_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sltsw_pkg::M_TDATA_W-1:0] m_axis_tdata;

    switch_tracker book = new();
    bit            tx_free = 1'b0;

    always #2 clk = ~clk;

    scheduled_led_time_switches dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // result side: free-running stretches alternate with random stalls
    int unsigned hold_left = 0;
    int          phase_left = 0;
    bit          rx_free = 1'b1;

    always @(posedge clk)
    begin
        if (phase_left <= 0)
        begin
            rx_free = ($urandom_range(0, 2) == 0);
            phase_left = $urandom_range(50, 400);
        end
        phase_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_free && $urandom_range(0, 2) == 0)
        begin
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                    : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            book.compare_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tx_free || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // every field random, kind as given
    function automatic switch_beat_t noise_beat(logic func);
        switch_beat_t it;
        it.func     = func;
        it.now_ms   = $urandom;
        it.index    = sltsw_pkg::IDX_IN_W'($urandom);
        it.enabled  = 1'($urandom);
        it.fire_at  = $urandom;
        it.target   = sltsw_pkg::OUT_W'($urandom);
        it.action   = sltsw_pkg::ACT_W'($urandom);
        it.repeats  = sltsw_pkg::REP_W'($urandom);
        it.interval = $urandom;
        return it;
    endfunction

    // drive one beat after a random gap and wait for its handshake
    task automatic send_beat(input switch_beat_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {7'd0, it.interval, it.repeats, it.action, it.target,
                          it.fire_at, it.enabled, it.index, it.now_ms};
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.take_item(it);
    endtask

    task automatic write_entry(input logic [sltsw_pkg::IDX_IN_W-1:0] index,
                               input logic enabled,
                               input logic [31:0] fire_at,
                               input logic [sltsw_pkg::OUT_W-1:0] target,
                               input logic [sltsw_pkg::ACT_W-1:0] action,
                               input logic signed [sltsw_pkg::REP_W-1:0] repeats,
                               input logic [31:0] interval);
        switch_beat_t it;
        it          = noise_beat(sltsw_pkg::FUNC_WRITE);
        it.index    = index;
        it.enabled  = enabled;
        it.fire_at  = fire_at;
        it.target   = target;
        it.action   = action;
        it.repeats  = repeats;
        it.interval = interval;
        send_beat(it);
    endtask

    task automatic tick_at(input logic [31:0] now_ms);
        switch_beat_t it;
        it        = noise_beat(sltsw_pkg::FUNC_TICK);
        it.now_ms = now_ms;
        send_beat(it);
    endtask

    // hold the input until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        switch_beat_t it;
        int           live[$];
        logic [31:0]  epoch;
        int           pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, zero repeat count, wrap with forever toggle
        tick_at(32'd0);
        write_entry(3'd0, 1'b1, 32'd0, sltsw_pkg::LED_FIRST, sltsw_pkg::ACT_ON,
                    16'sd0, 32'd0);
        tick_at(32'd0);
        tick_at(32'd0);
        write_entry(3'd7, 1'b1, 32'hFFFF_FFFF, sltsw_pkg::LED_LAST,
                    sltsw_pkg::ACT_TOGGLE, -16'sd1, 32'd1);
        tick_at(32'hFFFF_FFFF);
        tick_at(32'd0);
        // counted repeats on an entry with no led
        write_entry(3'd1, 1'b1, 32'd100, LED_NONE, sltsw_pkg::ACT_ON, 16'sd2, 32'd10);
        tick_at(32'd100);
        tick_at(32'd110);
        tick_at(32'd120);
        tick_at(32'd130);
        // out-of-range led and the unused action
        write_entry(3'd2, 1'b1, 32'd200, 3'd7, sltsw_pkg::ACT_ON, 16'sd1, 32'd5);
        tick_at(32'd200);
        write_entry(3'd3, 1'b1, 32'd300, 3'd2, ACT_NONE, 16'sd0, 32'd0);
        tick_at(32'd300);
        // two entries on one led at once, extreme counts and intervals
        write_entry(3'd4, 1'b1, 32'd400, 3'd3, sltsw_pkg::ACT_ON, 16'sh7FFF,
                    32'hFFFF_FFFF);
        write_entry(3'd5, 1'b1, 32'd400, 3'd3, sltsw_pkg::ACT_OFF, 16'sh8000,
                    32'h8000_0000);
        tick_at(32'd400);
        // disabled entry, then enabled with zero interval forever
        write_entry(3'd6, 1'b0, 32'd500, 3'd2, sltsw_pkg::ACT_TOGGLE, -16'sd1, 32'd0);
        tick_at(32'd500);
        write_entry(3'd6, 1'b1, 32'd500, 3'd2, sltsw_pkg::ACT_TOGGLE, -16'sd1, 32'd0);
        tick_at(32'd500);
        tick_at(32'd500);
        drain();

        // random: writes around a moving time base, ticks mostly on fire times
        epoch = $urandom;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 150 == 0)
                tx_free = ($urandom_range(0, 2) == 0);
            if (n % 100 == 0)
                epoch = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                    : $urandom;
            if (n == 600 || n == 1200)
                drain();

            live = {};
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (book.slot_on[k])
                    live.push_back(k);

            if ($urandom_range(0, 9) < 3)
            begin
                it = noise_beat(sltsw_pkg::FUNC_WRITE);
                it.enabled = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 4))
                    1, 2:    it.fire_at = epoch + $urandom_range(0, 30);
                    3:       it.fire_at = (live.size() != 0)
                                 ? book.slot_at[live[$urandom_range(0, live.size() - 1)]]
                                 : epoch;
                    4:       it.fire_at = 32'hFFFF_FFFF - $urandom_range(0, 20);
                    default: ;
                endcase
                if ($urandom_range(0, 4) != 0)
                    it.target = sltsw_pkg::OUT_W'($urandom_range(sltsw_pkg::LED_FIRST,
                                                                 sltsw_pkg::LED_LAST));
                if ($urandom_range(0, 9) != 0)
                    it.action = sltsw_pkg::ACT_W'($urandom_range(sltsw_pkg::ACT_ON,
                                                                 sltsw_pkg::ACT_TOGGLE));
                case ($urandom_range(0, 5))
                    0:       it.repeats = 16'sd0;
                    1, 2:    it.repeats = sltsw_pkg::REP_W'($urandom_range(1, 6));
                    3:       it.repeats = -$signed(16'($urandom_range(1, 3)));
                    5:       it.repeats = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    default: ;
                endcase
                case ($urandom_range(0, 5))
                    0:       it.interval = 32'd0;
                    1, 2, 3: it.interval = $urandom_range(1, 25);
                    5:       it.interval = 32'hFFFF_FFFF - $urandom_range(0, 5);
                    default: ;
                endcase
            end
            else
            begin
                it = noise_beat(sltsw_pkg::FUNC_TICK);
                pick = $urandom_range(0, 99);
                if (pick < 60 && live.size() != 0)
                    it.now_ms = book.slot_at[live[$urandom_range(0, live.size() - 1)]];
                else if (pick < 85)
                    it.now_ms = epoch + $urandom_range(0, 40);
            end
            send_beat(it);
        end

        // let any stray result show up before the verdict
        drain();
        repeat (24) @(posedge clk);

        $display("covered %0d entry writes and %0d ticks, %0d of them firing",
                 book.writes, book.ticks, book.firing_ticks);
        $display("%0d ticks fired several entries, %0d result beats checked, %0d mismatches",
                 book.multi_fires, book.checked, book.fail_count);
        if (book.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/sltsw_pkg.sv
src/sltsw_ram.sv
src/sltsw_unit.sv
src/scheduled_led_time_switches.sv
tb/scheduled_led_time_switches_test.sv
